// File: hdl/vzd_pkg.sv
// ----------------------------------------------------------------------------
// vzd_pkg
// Shared types and constants for the varint / zigzag decoder.
// ----------------------------------------------------------------------------
package vzd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned LimitW   = ValueW - GroupW;

  // Bit 7 of a stream byte: more bytes of this value follow.
  localparam int unsigned ContBit  = 7;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [LimitW-1:0] limit_t;

  // Outcome of one decode step, handed from the accumulator to the top level.
  typedef struct packed {
    logic               emit;
    logic               overflow;
    logic               was_zigzag;
    value_t             raw_value;
    logic signed [ValueW-1:0] signed_value;
  } vzd_result_t;

endpackage

// File: hdl/vzd_if.sv
// ----------------------------------------------------------------------------
// vzd_in_if / vzd_out_if
// Valid/ready channels for stream bytes and decoded values.
// ----------------------------------------------------------------------------
interface vzd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [63:0] value_limit;
  logic        zigzag_mode;

  modport source (output valid, output data_byte, output value_limit,
                  output zigzag_mode, input ready);
  modport sink   (input valid, input data_byte, input value_limit,
                  input zigzag_mode, output ready);
endinterface

interface vzd_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        raw_value;
  logic signed [63:0] signed_value;
  logic               was_zigzag;
  logic               overflow;

  modport source (output valid, output raw_value, output signed_value,
                  output was_zigzag, output overflow, input ready);
  modport sink   (input valid, input raw_value, input signed_value,
                  input was_zigzag, input overflow, output ready);
endinterface

// File: hdl/vzd_accum.sv
// ----------------------------------------------------------------------------
// vzd_accum
// Per-value decode state and the combinational merge / overflow / zigzag step.
// ----------------------------------------------------------------------------
module vzd_accum import vzd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  byte_t       data_byte_i,
  input  value_t      value_limit_i,
  input  logic        zigzag_mode_i,
  output vzd_result_t result_o
);

  value_t acc_q, acc_d;
  logic   in_value_q, in_value_d;
  limit_t lim_q, lim_d;
  logic   zz_q, zz_d;

  value_t acc_base;
  limit_t lim_cur;
  logic   zz_cur;
  logic   ovf;
  value_t merged;
  value_t half;

  always_comb begin
    // First byte of a value starts from zero with freshly sampled limit/mode.
    acc_base = in_value_q ? acc_q : '0;
    lim_cur  = in_value_q ? lim_q : value_limit_i[ValueW-1:GroupW];
    zz_cur   = in_value_q ? zz_q  : zigzag_mode_i;
    ovf      = acc_base > {{GroupW{1'b0}}, lim_cur};
    merged   = {acc_base[ValueW-GroupW-1:0], data_byte_i[GroupW-1:0]};
    half     = merged >> 1;
  end

  always_comb begin
    result_o.emit       = ovf || !data_byte_i[ContBit];
    result_o.overflow   = ovf;
    result_o.was_zigzag = ovf ? 1'b0 : zz_cur;
    result_o.raw_value  = ovf ? '0 : merged;
    if (ovf) begin
      result_o.signed_value = '0;
    end else if (merged[0]) begin
      result_o.signed_value = ~half;
    end else begin
      result_o.signed_value = half;
    end
  end

  always_comb begin
    acc_d      = acc_q;
    in_value_d = in_value_q;
    lim_d      = lim_q;
    zz_d       = zz_q;
    if (step_i) begin
      lim_d = lim_cur;
      zz_d  = zz_cur;
      if (ovf || !data_byte_i[ContBit]) begin
        acc_d      = '0;
        in_value_d = 1'b0;
      end else begin
        acc_d      = merged;
        in_value_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      in_value_q <= 1'b0;
      lim_q      <= '0;
      zz_q       <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      in_value_q <= in_value_d;
      lim_q      <= lim_d;
      zz_q       <= zz_d;
    end
  end

`ifndef SYNTHESIS
  // A value's first byte sees an empty accumulator and cannot overflow.
  a_no_first_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !in_value_q |-> !result_o.overflow)
    else $error("overflow on first byte of a value");

  a_cont_keeps_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !result_o.emit |=> in_value_q)
    else $error("continuation byte did not keep value open");

  a_emit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.emit |=> !in_value_q && acc_q == '0)
    else $error("result emitted but value still open");
`endif

endmodule

// File: hdl/varint_zigzag_decoder_unit.sv
// ----------------------------------------------------------------------------
// varint_zigzag_decoder_unit
// MSB-first base-128 varint decoder with zigzag decode of each value.
// ----------------------------------------------------------------------------
// One stream byte per transaction, one byte per cycle sustained while results
// are accepted. A byte is captured in an input register, then merged into
// the running value and, when it ends a value or overflows the limit that
// was sampled on the value's first byte, a result is written to the output
// register. While a result waits unaccepted, the input register takes one
// more byte and then the input stalls until the output register drains; a
// continuation byte waits there too. Continuation bytes give no result
// transaction.
module varint_zigzag_decoder_unit import vzd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  vzd_in_if.sink    byte_i,
  vzd_out_if.source result_o
);

  logic        s1_valid_q, s1_valid_d;
  byte_t       s1_byte_q;
  value_t      s1_limit_q;
  logic        s1_zz_q;

  logic        out_valid_q, out_valid_d;
  vzd_result_t out_q;

  logic        out_free;
  logic        step;
  logic        in_take;
  vzd_result_t step_res;

  assign out_free     = !out_valid_q || result_o.ready;
  assign step         = s1_valid_q && out_free;
  assign byte_i.ready = !s1_valid_q || out_free;
  assign in_take      = byte_i.valid && byte_i.ready;

  vzd_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (s1_byte_q),
    .value_limit_i (s1_limit_q),
    .zigzag_mode_i (s1_zz_q),
    .result_o      (step_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && !result_o.ready;
    if (step) begin
      out_valid_d = step_res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= byte_i.data_byte;
      s1_limit_q <= byte_i.value_limit;
      s1_zz_q    <= byte_i.zigzag_mode;
    end
    if (step && step_res.emit) begin
      out_q <= step_res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.raw_value    = out_q.raw_value;
  assign result_o.signed_value = out_q.signed_value;
  assign result_o.was_zigzag   = out_q.was_zigzag;
  assign result_o.overflow     = out_q.overflow;

`ifndef SYNTHESIS
  a_ovf_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow |->
      out_q.raw_value == '0 && out_q.signed_value == '0 && !out_q.was_zigzag)
    else $error("overflow result carries nonzero fields");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input stage lost a byte while output stalled");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step))
    else $error("result appeared without a decode step");
`endif

endmodule
